FILE: sv/aef_pkg.sv
package aef_pkg;

    localparam int AEF_NUM_REGS = 16;
    localparam int AEF_DATA_W   = 64;
    localparam int AEF_IDX_W    = 4;
    localparam int AEF_CMD_W    = 4;
    localparam int AEF_SHIFT_W  = 6;

    typedef enum logic [AEF_CMD_W-1:0] {
        OP_AND = 4'h0,
        OP_OR  = 4'h1,
        OP_XOR = 4'h2,
        OP_ADD = 4'h3,
        OP_ADC = 4'h4,
        OP_CMP = 4'h5,
        OP_SUB = 4'h6,
        OP_SBC = 4'h7,
        OP_MOV = 4'h8,
        OP_LSH = 4'h9,
        OP_RSH = 4'hA
    } t_op;

    typedef struct packed {
        logic [AEF_CMD_W-1:0]         command;
        logic [AEF_IDX_W-1:0]         dest_reg;
        logic [AEF_IDX_W-1:0]         first_reg;
        logic [AEF_IDX_W-1:0]         second_reg;
        logic                         use_immediate;
        logic signed [AEF_DATA_W-1:0] immediate;
    } t_req;

    typedef struct packed {
        logic [AEF_DATA_W-1:0] result_value;
        logic                  wrote_register;
        logic                  carry_out;
        logic                  zero_out;
        logic                  sign_out;
        logic                  bad_opcode;
    } t_rsp;

    typedef struct packed {
        logic carry;
        logic zero;
        logic sign;
    } t_flags;

    typedef struct packed {
        logic [AEF_DATA_W-1:0] result;
        logic                  wr_op;
        logic                  bad;
        t_flags                flags;
    } t_alu_res;

endpackage

FILE: sv/aef_stream_if.sv
interface aef_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: sv/aef_ram.sv
module aef_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

FILE: sv/aef_alu.sv
module aef_alu
    import aef_pkg::*;
(
    input  logic [AEF_CMD_W-1:0]  i_command,
    input  logic [AEF_DATA_W-1:0] i_a,
    input  logic [AEF_DATA_W-1:0] i_b,
    input  t_flags                i_flags,
    output t_alu_res              o_res
);
    logic [AEF_DATA_W:0]   sum;
    logic [AEF_DATA_W-1:0] diff;
    logic                  borrow;
    logic                  cin;
    logic                  big_shift;
    logic [AEF_SHIFT_W-1:0] sh;
    logic [AEF_DATA_W-1:0] lmask;
    logic [AEF_DATA_W-1:0] rmask;
    logic [AEF_DATA_W-1:0] r;

    always_comb begin
        cin       = (t_op'(i_command) == OP_ADC) ? i_flags.carry : 1'b0;
        sum       = {1'b0, i_a} + {1'b0, i_b} + {{AEF_DATA_W{1'b0}}, cin};
        borrow    = (t_op'(i_command) == OP_SBC) ? ~i_flags.carry : 1'b0;
        diff      = i_a - i_b - {{(AEF_DATA_W-1){1'b0}}, borrow};
        big_shift = |i_b[AEF_DATA_W-1:AEF_SHIFT_W];
        sh        = i_b[AEF_SHIFT_W-1:0];
        // Bits that leave the word for a left or a right shift by sh.
        lmask     = ~({AEF_DATA_W{1'b1}} >> sh);
        rmask     = ~({AEF_DATA_W{1'b1}} << sh);

        r           = '0;
        o_res.wr_op = 1'b1;
        o_res.bad   = 1'b0;
        o_res.flags = i_flags;
        unique case (t_op'(i_command))
            OP_AND: begin
                r = i_a & i_b;
                o_res.flags.carry = 1'b0;
            end
            OP_OR: begin
                r = i_a | i_b;
                o_res.flags.carry = 1'b0;
            end
            OP_XOR: begin
                r = i_a ^ i_b;
                o_res.flags.carry = 1'b0;
            end
            OP_ADD, OP_ADC: begin
                r = sum[AEF_DATA_W-1:0];
                o_res.flags.carry = sum[AEF_DATA_W];
            end
            OP_CMP, OP_SUB, OP_SBC: begin
                r = diff;
                o_res.flags.carry = ((i_a[AEF_DATA_W-1] ^ i_b[AEF_DATA_W-1]) &
                                     (i_a[AEF_DATA_W-1] ^ diff[AEF_DATA_W-1]));
                o_res.wr_op = (t_op'(i_command) != OP_CMP);
            end
            OP_MOV: begin
                r = i_b;
            end
            OP_LSH: begin
                r = big_shift ? '0 : (i_a << sh);
                o_res.flags.carry = big_shift ? (|i_a) : (|(i_a & lmask));
            end
            OP_RSH: begin
                r = big_shift ? '0 : (i_a >> sh);
                o_res.flags.carry = big_shift ? (|i_a) : (|(i_a & rmask));
            end
            default: begin
                o_res.wr_op = 1'b0;
                o_res.bad   = 1'b1;
            end
        endcase

        // Move and undefined opcodes leave zero and sign alone.
        if (!o_res.bad && t_op'(i_command) != OP_MOV) begin
            o_res.flags.zero = (r == '0);
            o_res.flags.sign = r[AEF_DATA_W-1];
        end
        o_res.result = r;
    end
endmodule

FILE: sv/alu_execute_with_flags_top.sv
// Execute stage over a file of NUM_REGS 64-bit registers with carry, zero
// and sign flags. Requests arrive on i_req (valid/ready); each request names
// an opcode, a destination, a first source register and a second operand
// that is either a register or the 64-bit immediate. Every request yields
// exactly one response on o_rsp with the written value, a write indication,
// the three flags after the instruction and an error bit for an undefined
// opcode (which changes no state).
// The register file sits in two copies of a single-port-read RAM, one per
// source operand, both written with the same data. The read is issued on
// the edge that accepts a request; the ALU then works on the read data and
// writes back as the execute stage advances. The most recent write is held
// in a bypass register so a request that reads the register written by its
// direct predecessor sees the new value. Flags live in flip-flops.
// The response is registered behind the execute stage register. One
// request is accepted per cycle while the receiver does not stall, since
// every request needs at most one RAM write and one combinational ALU pass.
// Reset clears the flags and a per-register valid bit, so every register
// reads as zero until written; no clearing pass is needed. When the
// receiver stalls, the response register holds and the execute stage keeps
// its request; i_req.ready drops only when both are full and stalled.
module alu_execute_with_flags_top
    import aef_pkg::*;
#(
    parameter int NUM_REGS = AEF_NUM_REGS
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    aef_stream_if.sink   i_req,
    aef_stream_if.source o_rsp
);
    localparam int AW = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;

    // Execute stage registers.
    logic                  r_s1_valid;
    t_req                  r_s1_req;
    // Response register.
    logic                  r_out_valid;
    t_rsp                  r_out;
    // Architectural flags and register-valid bits.
    t_flags                r_flags;
    logic [NUM_REGS-1:0]   r_reg_valid;
    // Bypass of the latest register write.
    logic                  r_fwd_valid;
    logic [AW-1:0]         r_fwd_addr;
    logic [AEF_DATA_W-1:0] r_fwd_data;

    logic                  accept;
    logic                  s1_adv;
    logic [AEF_DATA_W-1:0] ram_a;
    logic [AEF_DATA_W-1:0] ram_b;
    logic [AW-1:0]         first_addr;
    logic [AW-1:0]         second_addr;
    logic [AW-1:0]         dest_addr;
    logic                  first_ok;
    logic                  second_ok;
    logic                  dest_ok;
    logic [AEF_DATA_W-1:0] op_a;
    logic [AEF_DATA_W-1:0] reg_b;
    logic [AEF_DATA_W-1:0] op_b;
    t_alu_res              alu;
    logic                  do_write;
    t_rsp                  n_out;

    assign s1_adv      = r_s1_valid && (!r_out_valid || o_rsp.ready);
    assign i_req.ready = !r_s1_valid || s1_adv;
    assign accept      = i_req.valid && i_req.ready;

    aef_ram #(.WIDTH(AEF_DATA_W), .DEPTH(NUM_REGS)) u_ram_a (
        .i_clk   (i_clk),
        .i_we    (do_write),
        .i_waddr (dest_addr),
        .i_wdata (alu.result),
        .i_re    (accept),
        .i_raddr (AW'(i_req.data.first_reg)),
        .o_rdata (ram_a)
    );

    aef_ram #(.WIDTH(AEF_DATA_W), .DEPTH(NUM_REGS)) u_ram_b (
        .i_clk   (i_clk),
        .i_we    (do_write),
        .i_waddr (dest_addr),
        .i_wdata (alu.result),
        .i_re    (accept),
        .i_raddr (AW'(i_req.data.second_reg)),
        .o_rdata (ram_b)
    );

    // Operand selection: out-of-range indexes and never-written registers
    // read as zero; a write made on the read edge comes from the bypass.
    always_comb begin
        first_addr  = AW'(r_s1_req.first_reg);
        second_addr = AW'(r_s1_req.second_reg);
        dest_addr   = AW'(r_s1_req.dest_reg);
        first_ok    = 32'(r_s1_req.first_reg) < NUM_REGS;
        second_ok   = 32'(r_s1_req.second_reg) < NUM_REGS;
        dest_ok     = 32'(r_s1_req.dest_reg) < NUM_REGS;

        if (!first_ok) begin
            op_a = '0;
        end else if (r_fwd_valid && r_fwd_addr == first_addr) begin
            op_a = r_fwd_data;
        end else if (r_reg_valid[first_addr]) begin
            op_a = ram_a;
        end else begin
            op_a = '0;
        end

        if (!second_ok) begin
            reg_b = '0;
        end else if (r_fwd_valid && r_fwd_addr == second_addr) begin
            reg_b = r_fwd_data;
        end else if (r_reg_valid[second_addr]) begin
            reg_b = ram_b;
        end else begin
            reg_b = '0;
        end

        op_b = r_s1_req.use_immediate ? AEF_DATA_W'(r_s1_req.immediate) : reg_b;
    end

    aef_alu u_alu (
        .i_command (r_s1_req.command),
        .i_a       (op_a),
        .i_b       (op_b),
        .i_flags   (r_flags),
        .o_res     (alu)
    );

    always_comb begin
        do_write             = s1_adv && alu.wr_op && dest_ok;
        n_out.result_value   = (alu.wr_op && dest_ok) ? alu.result : '0;
        n_out.wrote_register = alu.wr_op && dest_ok;
        n_out.carry_out      = alu.flags.carry;
        n_out.zero_out       = alu.flags.zero;
        n_out.sign_out       = alu.flags.sign;
        n_out.bad_opcode     = alu.bad;
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_flags     <= '0;
            r_reg_valid <= '0;
            r_fwd_valid <= 1'b0;
        end else begin
            if (i_req.ready) begin
                r_s1_valid <= i_req.valid;
            end
            if (s1_adv) begin
                r_out_valid <= 1'b1;
                r_flags     <= alu.flags;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
            if (do_write) begin
                r_reg_valid[dest_addr] <= 1'b1;
                r_fwd_valid            <= 1'b1;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_req <= i_req.data;
        end
        if (s1_adv) begin
            r_out <= n_out;
        end
        if (do_write) begin
            r_fwd_addr <= dest_addr;
            r_fwd_data <= alu.result;
        end
    end

    assign o_rsp.valid = r_out_valid;
    assign o_rsp.data  = r_out;
endmodule
